/* hdl/lccc_pkg.sv */
// lccc_pkg: shared widths, constants and codes for the lattice coefficient
// compression codec
// no dependencies
`default_nettype none

package lccc_pkg;

    // group geometry
    localparam int unsigned GROUP   = 8;
    localparam int unsigned COEF_W  = 13;
    localparam int unsigned PACK_W  = 56;
    localparam int unsigned WIDTH_W = 3;
    localparam int unsigned FIELD_W = 7;

    // default modulus
    localparam int unsigned MODULUS_DEF = 7681;

    // compressed width after reset
    localparam logic [WIDTH_W-1:0] BITS_PER_COEF_RST = 3'd3;

    // item mode codes
    localparam logic MODE_COMPRESS   = 1'b0;
    localparam logic MODE_DECOMPRESS = 1'b1;

endpackage : lccc_pkg

`default_nettype wire

/* hdl/lccc_if.sv */
// lccc_if: valid/ready channel interfaces for the codec (request, response,
// configuration write)
// depends on lccc_pkg
`default_nettype none

interface lccc_req_if;
    import lccc_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [COEF_W-1:0]   coef_in0;
    logic [COEF_W-1:0]   coef_in1;
    logic [COEF_W-1:0]   coef_in2;
    logic [COEF_W-1:0]   coef_in3;
    logic [COEF_W-1:0]   coef_in4;
    logic [COEF_W-1:0]   coef_in5;
    logic [COEF_W-1:0]   coef_in6;
    logic [COEF_W-1:0]   coef_in7;
    logic [PACK_W-1:0]   packed_in;

    modport source (
        output valid, mode, coef_in0, coef_in1, coef_in2, coef_in3,
               coef_in4, coef_in5, coef_in6, coef_in7, packed_in,
        input  ready
    );
    modport sink (
        input  valid, mode, coef_in0, coef_in1, coef_in2, coef_in3,
               coef_in4, coef_in5, coef_in6, coef_in7, packed_in,
        output ready
    );
endinterface : lccc_req_if

interface lccc_rsp_if;
    import lccc_pkg::*;

    logic                valid;
    logic                ready;
    logic [PACK_W-1:0]   packed_out;
    logic [COEF_W-1:0]   coef_out0;
    logic [COEF_W-1:0]   coef_out1;
    logic [COEF_W-1:0]   coef_out2;
    logic [COEF_W-1:0]   coef_out3;
    logic [COEF_W-1:0]   coef_out4;
    logic [COEF_W-1:0]   coef_out5;
    logic [COEF_W-1:0]   coef_out6;
    logic [COEF_W-1:0]   coef_out7;

    modport source (
        output valid, packed_out, coef_out0, coef_out1, coef_out2, coef_out3,
               coef_out4, coef_out5, coef_out6, coef_out7,
        input  ready
    );
    modport sink (
        input  valid, packed_out, coef_out0, coef_out1, coef_out2, coef_out3,
               coef_out4, coef_out5, coef_out6, coef_out7,
        output ready
    );
endinterface : lccc_rsp_if

interface lccc_cfg_if;
    import lccc_pkg::*;

    logic                valid;
    logic                ready;
    logic [WIDTH_W-1:0]  bits_per_coef;

    modport source (
        output valid, bits_per_coef,
        input  ready
    );
    modport sink (
        input  valid, bits_per_coef,
        output ready
    );
endinterface : lccc_cfg_if

`default_nettype wire

/* hdl/lattice_coef_compress_codec_unit.sv */
// Lattice coefficient compression codec, top level: eight-lane compress and
// decompress datapath in three register stages
// depends on lccc_pkg and the channel interfaces in lccc_if
//
// Takes one group of eight coefficients (compress) or one packed word
// (decompress) per transfer and returns exactly one result per group, in
// order. A new group is accepted every cycle unless the pipeline is stalled.
// Stage one forms the scaled operand or extracts the d-bit fields, stage two
// runs one multiplier per lane (reciprocal of the modulus, or the modulus
// itself), stage three masks and packs or shifts down to coefficients into
// the output registers. Backpressure is handled stage by stage, so a stalled
// response holds and bubbles are squeezed out. The compressed width is set
// through the configuration channel; the user must do so only while the
// block is idle (not enforced by the block). A width of zero acts as one.
`default_nettype none

module lattice_coef_compress_codec_unit #(
    parameter int unsigned MODULUS = lccc_pkg::MODULUS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lccc_req_if.sink  req,
    lccc_rsp_if.source rsp,
    lccc_cfg_if.sink  cfg
);
    import lccc_pkg::*;

    // operand width: (13-bit coefficient << 7) + modulus/2 stays below 2^21
    localparam int unsigned OPND_W  = COEF_W + FIELD_W + 1;
    localparam int unsigned QW      = $clog2(MODULUS);
    localparam int unsigned SHIFT_K = OPND_W + QW;
    localparam int unsigned RECIP_W = OPND_W + 2;
    localparam int unsigned PROD_W  = OPND_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT_K) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_FULL[RECIP_W-1:0];
    localparam logic [OPND_W-1:0]  HALF_Q = OPND_W'(MODULUS / 2);
    localparam logic [OPND_W-1:0]  Q_OPND = OPND_W'(MODULUS);
    localparam int unsigned POS_W = $clog2(PACK_W);

    // configuration register
    logic [WIDTH_W-1:0] width_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= BITS_PER_COEF_RST;
        end
        else if (cfg.valid)
        begin
            width_reg <= cfg.bits_per_coef;
        end
    end

    // pipeline valid bits and stage handshakes
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready  = !s3_valid_reg || rsp.ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage one: scale coefficients or pull out the d-bit fields
    logic [COEF_W-1:0]  coef_arr [GROUP];
    logic [WIDTH_W-1:0] d_eff;
    logic [FIELD_W-1:0] fmask_in;
    logic [OPND_W-1:0]  s1_opnd_next [GROUP];
    logic [OPND_W-1:0]  s1_opnd_reg  [GROUP];
    logic               s1_mode_reg;
    logic [WIDTH_W-1:0] s1_width_reg;

    assign coef_arr[0] = req.coef_in0;
    assign coef_arr[1] = req.coef_in1;
    assign coef_arr[2] = req.coef_in2;
    assign coef_arr[3] = req.coef_in3;
    assign coef_arr[4] = req.coef_in4;
    assign coef_arr[5] = req.coef_in5;
    assign coef_arr[6] = req.coef_in6;
    assign coef_arr[7] = req.coef_in7;

    assign d_eff    = (width_reg == '0) ? WIDTH_W'(1) : width_reg;
    assign fmask_in = FIELD_W'((8'd1 << d_eff) - 8'd1);

    always_comb
    begin
        logic [POS_W-1:0]  pos;
        logic [PACK_W-1:0] sh;
        for (int j = 0; j < GROUP; j++)
        begin
            pos = POS_W'(j) * POS_W'(d_eff);
            sh  = req.packed_in >> pos;
            if (req.mode == MODE_COMPRESS)
            begin
                s1_opnd_next[j] = (OPND_W'(coef_arr[j]) << d_eff) + HALF_Q;
            end
            else
            begin
                s1_opnd_next[j] = OPND_W'(sh[FIELD_W-1:0] & fmask_in);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_mode_reg  <= req.mode;
            s1_width_reg <= d_eff;
            for (int j = 0; j < GROUP; j++)
            begin
                s1_opnd_reg[j] <= s1_opnd_next[j];
            end
        end
    end

    // stage two: one multiplier per lane, quotient by reciprocal or f*q + half
    logic [OPND_W-1:0]  s2_val_next [GROUP];
    logic [OPND_W-1:0]  s2_val_reg  [GROUP];
    logic               s2_mode_reg;
    logic [WIDTH_W-1:0] s2_width_reg;

    always_comb
    begin
        logic [PROD_W-1:0] prod;
        for (int j = 0; j < GROUP; j++)
        begin
            prod = PROD_W'(s1_opnd_reg[j]) * PROD_W'(RECIP);
            if (s1_mode_reg == MODE_COMPRESS)
            begin
                s2_val_next[j] = OPND_W'(prod[SHIFT_K +: FIELD_W]);
            end
            else
            begin
                s2_val_next[j] = OPND_W'(s1_opnd_reg[j][FIELD_W-1:0]) * Q_OPND
                               + (OPND_W'(1) << (s1_width_reg - WIDTH_W'(1)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_width_reg <= s1_width_reg;
            for (int j = 0; j < GROUP; j++)
            begin
                s2_val_reg[j] <= s2_val_next[j];
            end
        end
    end

    // stage three: mask and pack, or shift down to coefficients
    logic [PACK_W-1:0]  packed_next;
    logic [COEF_W-1:0]  coef_next [GROUP];
    logic [PACK_W-1:0]  packed_reg;
    logic [COEF_W-1:0]  coef_reg  [GROUP];
    logic [FIELD_W-1:0] fmask_s2;

    assign fmask_s2 = FIELD_W'((8'd1 << s2_width_reg) - 8'd1);

    always_comb
    begin
        logic [POS_W-1:0] pos;
        packed_next = '0;
        for (int j = 0; j < GROUP; j++)
        begin
            pos = POS_W'(j) * POS_W'(s2_width_reg);
            if (s2_mode_reg == MODE_COMPRESS)
            begin
                packed_next  = packed_next
                             | (PACK_W'(s2_val_reg[j][FIELD_W-1:0] & fmask_s2) << pos);
                coef_next[j] = '0;
            end
            else
            begin
                coef_next[j] = COEF_W'(s2_val_reg[j] >> s2_width_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            packed_reg <= packed_next;
            for (int j = 0; j < GROUP; j++)
            begin
                coef_reg[j] <= coef_next[j];
            end
        end
    end

    // response channel
    assign rsp.valid      = s3_valid_reg;
    assign rsp.packed_out = packed_reg;
    assign rsp.coef_out0  = coef_reg[0];
    assign rsp.coef_out1  = coef_reg[1];
    assign rsp.coef_out2  = coef_reg[2];
    assign rsp.coef_out3  = coef_reg[3];
    assign rsp.coef_out4  = coef_reg[4];
    assign rsp.coef_out5  = coef_reg[5];
    assign rsp.coef_out6  = coef_reg[6];
    assign rsp.coef_out7  = coef_reg[7];

endmodule : lattice_coef_compress_codec_unit

`default_nettype wire

/* hdl/lccc_checker.sv */
// lccc_checker: port-level assertions for the codec top level, with the bind
// that attaches it
// depends on lccc_pkg and lattice_coef_compress_codec_unit
`default_nettype none

module lccc_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic [lccc_pkg::PACK_W-1:0] packed_out,
    input wire logic [lccc_pkg::COEF_W-1:0] coef_out0,
    input wire logic [lccc_pkg::COEF_W-1:0] coef_out7
);
    import lccc_pkg::*;

    // groups in flight, between request transfer and response transfer
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       req_xfer;
    logic       rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_xfer && !rsp_xfer)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (!req_xfer && rsp_xfer)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a response only follows an accepted group
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (inflight_reg != 2'd0))
        else $error("response without an outstanding group");

    // never more than three groups held inside
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == 2'd3) |-> (!req_xfer || rsp_xfer))
        else $error("group accepted with the pipeline full");

    // a stalled response stays valid
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response dropped while stalled");

    // a stalled response keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            ($stable(packed_out) && $stable(coef_out0) && $stable(coef_out7)))
        else $error("response payload changed while stalled");

endmodule : lccc_checker

bind lattice_coef_compress_codec_unit lccc_checker u_lccc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .packed_out (rsp.packed_out),
    .coef_out0  (rsp.coef_out0),
    .coef_out7  (rsp.coef_out7)
);

`default_nettype wire
